[src/cpl_pkg.sv]
`timescale 1ns / 1ps

package cpl_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CW        = 32;
	localparam int THR_W     = 32;
	localparam int P_W       = CW + 1;
	localparam int PR_W      = P_W + CW;
	localparam int DOT_W     = PR_W + 2;
	localparam int WIDE_W    = 131;
	localparam int DEN_MW    = WIDE_W - 2;
	localparam int MAG_W     = 64;
	localparam int NQA_W     = WIDE_W - 1 + FRAC_BITS;
	localparam int NQB_W     = NQA_W + MAG_W + 1;
	localparam int PA_W      = NQA_W + CW;
	localparam int PB_W      = NQB_W + CW;
	localparam int BW        = PB_W + 2;

	// wide multiplies are cut into chunk products, summed in the next stage
	localparam int CHUNK     = 32;
	localparam int MA_N      = 7;
	localparam int MB_N      = 2;
	localparam int MA_W      = MA_N * CHUNK;
	localparam int MB_W      = MB_N * CHUNK;
	localparam int MP_W      = MA_W + MB_W;

	typedef logic [MA_N-1:0][MB_N-1:0][2*CHUNK-1:0] pp_t;

	typedef struct packed {
		logic [2:0][CW-1:0] oa;
		logic [2:0][CW-1:0] da;
		logic [2:0][CW-1:0] ob;
		logic [2:0][CW-1:0] db;
	} geom_t;

	typedef struct packed {
		geom_t              g;
		logic               found;
		logic [DOT_W-1:0]   d1343;
		logic [DOT_W-1:0]   d4321;
		logic [MAG_W-1:0]   d4343;
		logic [DEN_MW-1:0]  den;
		logic [DEN_MW-1:0]  rem;
		logic [NQA_W-1:0]   nq;
		logic               neg;
	} diva_t;

	typedef struct packed {
		geom_t              g;
		logic               found;
		logic               neg_a;
		logic [NQA_W-1:0]   mua;
		logic [MAG_W-1:0]   den;
		logic [MAG_W-1:0]   rem;
		logic [NQB_W-1:0]   nq;
		logic               neg;
	} divb_t;

	typedef struct packed {
		logic [2:0][CW-1:0] point_a;
		logic [2:0][CW-1:0] point_b;
		logic               found;
	} res_t;

	function automatic pp_t pp_mul(logic [MA_W-1:0] a, logic [MB_W-1:0] b);
		pp_t r;
		for (int i = 0; i < MA_N; i++) begin
			for (int j = 0; j < MB_N; j++) begin
				r[i][j] = a[i*CHUNK +: CHUNK] * b[j*CHUNK +: CHUNK];
			end
		end
		return r;
	endfunction

	// chunk products of one row and parity do not overlap, so each row is plain wiring
	function automatic logic [MP_W-1:0] pp_sum(pp_t p);
		logic [MP_W-1:0] row [2*MB_N];
		logic [MP_W-1:0] acc;
		for (int k = 0; k < 2*MB_N; k++) begin
			row[k] = '0;
		end
		for (int i = 0; i < MA_N; i++) begin
			for (int j = 0; j < MB_N; j++) begin
				row[2*j + (i & 1)] = row[2*j + (i & 1)] |
					(MP_W'(p[i][j]) << (CHUNK*(i+j)));
			end
		end
		acc = '0;
		for (int k = 0; k < 2*MB_N; k++) begin
			acc = acc + row[k];
		end
		return acc;
	endfunction

endpackage

[src/cpl_if.sv]
`timescale 1ns / 1ps

interface cpl_query_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] origin_a_x;
	logic signed [31:0] origin_a_y;
	logic signed [31:0] origin_a_z;
	logic signed [31:0] dir_a_x;
	logic signed [31:0] dir_a_y;
	logic signed [31:0] dir_a_z;
	logic signed [31:0] origin_b_x;
	logic signed [31:0] origin_b_y;
	logic signed [31:0] origin_b_z;
	logic signed [31:0] dir_b_x;
	logic signed [31:0] dir_b_y;
	logic signed [31:0] dir_b_z;

	modport source (output valid, origin_a_x, origin_a_y, origin_a_z, dir_a_x, dir_a_y,
		dir_a_z, origin_b_x, origin_b_y, origin_b_z, dir_b_x, dir_b_y, dir_b_z,
		input ready);
	modport sink (input valid, origin_a_x, origin_a_y, origin_a_z, dir_a_x, dir_a_y,
		dir_a_z, origin_b_x, origin_b_y, origin_b_z, dir_b_x, dir_b_y, dir_b_z,
		output ready);
endinterface

interface cpl_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_a_x;
	logic signed [31:0] point_a_y;
	logic signed [31:0] point_a_z;
	logic signed [31:0] point_b_x;
	logic signed [31:0] point_b_y;
	logic signed [31:0] point_b_z;
	logic               found;

	modport source (output valid, point_a_x, point_a_y, point_a_z, point_b_x, point_b_y,
		point_b_z, found, input ready);
	modport sink (input valid, point_a_x, point_a_y, point_a_z, point_b_x, point_b_y,
		point_b_z, found, output ready);
endinterface

[src/cpl_front.sv]
`timescale 1ns / 1ps

module cpl_front
	import cpl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  geom_t            in_g,
	input  logic [THR_W-1:0] thr,
	output logic             out_v,
	output diva_t            out_d
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	geom_t g_s1, g_s2, g_s3, g_s4, g_s5;
	logic signed [P_W-1:0]    p13_s1 [3];
	logic signed [PR_W-1:0]   pd_s2 [3];
	logic signed [PR_W-1:0]   ad_s2 [3];
	logic signed [PR_W-1:0]   pa_s2 [3];
	logic signed [PR_W-1:0]   bb_s2 [3];
	logic signed [PR_W-1:0]   aa_s2 [3];
	logic signed [DOT_W-1:0]  d1343_s3, d4321_s3, d1321_s3, d4343_s3, d2121_s3;
	logic signed [DOT_W-1:0]  d1343_s4, d4321_s4, d4343_s4;
	logic signed [DOT_W-1:0]  d1343_s5, d4321_s5, d4343_s5;
	pp_t                      pp0_s4, pp1_s4, pp2_s4, pp3_s4;
	logic                     neg2_s4, neg3_s4;
	logic signed [WIDE_W-1:0] m0_s5, m1_s5, m2_s5, m3_s5;

	logic [DOT_W-1:0]          a1343, a4321, a1321;
	logic [MP_W-1:0]           sum0, sum1, sum2, sum3;
	logic signed [WIDE_W-1:0]  denom, numer;
	logic [WIDE_W-1:0]         den_abs, num_abs;
	logic [THR_W+2*FRAC_BITS-1:0] thr_sh;
	logic                      found;

	assign a1343 = d1343_s3[DOT_W-1] ? -d1343_s3 : d1343_s3;
	assign a4321 = d4321_s3[DOT_W-1] ? -d4321_s3 : d4321_s3;
	assign a1321 = d1321_s3[DOT_W-1] ? -d1321_s3 : d1321_s3;

	assign sum0 = pp_sum(pp0_s4);
	assign sum1 = pp_sum(pp1_s4);
	assign sum2 = pp_sum(pp2_s4);
	assign sum3 = pp_sum(pp3_s4);

	assign denom   = m0_s5 - m1_s5;
	assign numer   = m2_s5 - m3_s5;
	assign den_abs = denom[WIDE_W-1] ? -denom : denom;
	assign num_abs = numer[WIDE_W-1] ? -numer : numer;
	assign thr_sh  = {thr, {(2*FRAC_BITS){1'b0}}};
	assign found   = (denom != '0) && !(den_abs < WIDE_W'(thr_sh));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1  <= in_v;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			out_v <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1 <= in_g;
			for (int i = 0; i < 3; i++) begin
				p13_s1[i] <= {in_g.oa[i][CW-1], in_g.oa[i]} - {in_g.ob[i][CW-1], in_g.ob[i]};
			end
			// products
			g_s2 <= g_s1;
			for (int i = 0; i < 3; i++) begin
				pd_s2[i] <= p13_s1[i] * $signed(g_s1.db[i]);
				pa_s2[i] <= p13_s1[i] * $signed(g_s1.da[i]);
				ad_s2[i] <= $signed(g_s1.db[i]) * $signed(g_s1.da[i]);
				bb_s2[i] <= $signed(g_s1.db[i]) * $signed(g_s1.db[i]);
				aa_s2[i] <= $signed(g_s1.da[i]) * $signed(g_s1.da[i]);
			end
			// dot products
			g_s3     <= g_s2;
			d1343_s3 <= pd_s2[0] + pd_s2[1] + pd_s2[2];
			d4321_s3 <= ad_s2[0] + ad_s2[1] + ad_s2[2];
			d1321_s3 <= pa_s2[0] + pa_s2[1] + pa_s2[2];
			d4343_s3 <= bb_s2[0] + bb_s2[1] + bb_s2[2];
			d2121_s3 <= aa_s2[0] + aa_s2[1] + aa_s2[2];
			// chunk products of the dots
			g_s4     <= g_s3;
			d1343_s4 <= d1343_s3;
			d4321_s4 <= d4321_s3;
			d4343_s4 <= d4343_s3;
			pp0_s4   <= pp_mul(MA_W'(d2121_s3), MB_W'(d4343_s3));
			pp1_s4   <= pp_mul(MA_W'(a4321), MB_W'(a4321));
			pp2_s4   <= pp_mul(MA_W'(a1343), MB_W'(a4321));
			pp3_s4   <= pp_mul(MA_W'(a1321), MB_W'(d4343_s3));
			neg2_s4  <= d1343_s3[DOT_W-1] ^ d4321_s3[DOT_W-1];
			neg3_s4  <= d1321_s3[DOT_W-1];
			// cross products of the dots
			g_s5     <= g_s4;
			d1343_s5 <= d1343_s4;
			d4321_s5 <= d4321_s4;
			d4343_s5 <= d4343_s4;
			m0_s5    <= sum0[WIDE_W-1:0];
			m1_s5    <= sum1[WIDE_W-1:0];
			m2_s5    <= neg2_s4 ? -sum2[WIDE_W-1:0] : sum2[WIDE_W-1:0];
			m3_s5    <= neg3_s4 ? -sum3[WIDE_W-1:0] : sum3[WIDE_W-1:0];
			// denominator, parallel test, divider setup
			out_d.g     <= g_s5;
			out_d.found <= found;
			out_d.d1343 <= d1343_s5;
			out_d.d4321 <= d4321_s5;
			out_d.d4343 <= d4343_s5[MAG_W-1:0];
			out_d.den   <= den_abs[DEN_MW-1:0];
			out_d.rem   <= '0;
			out_d.nq    <= {num_abs[WIDE_W-2:0], {FRAC_BITS{1'b0}}};
			out_d.neg   <= numer[WIDE_W-1] ^ denom[WIDE_W-1];
		end
	end

endmodule

[src/cpl_div_a.sv]
`timescale 1ns / 1ps

module cpl_div_a
	import cpl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_v,
	input  diva_t in_d,
	output logic  out_v,
	output diva_t out_d
);

	diva_t            div_s [NQA_W];
	logic [NQA_W-1:0] div_v_s;

	// one quotient bit per stage, restoring
	function automatic diva_t step_a(diva_t s);
		logic [DEN_MW:0] t;
		logic            ge;
		diva_t           r;
		r     = s;
		t     = {s.rem, s.nq[NQA_W-1]};
		ge    = t >= {1'b0, s.den};
		r.rem = ge ? DEN_MW'(t - {1'b0, s.den}) : t[DEN_MW-1:0];
		r.nq  = {s.nq[NQA_W-2:0], ge};
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s <= '0;
		end else if (en) begin
			div_v_s <= {div_v_s[NQA_W-2:0], in_v};
		end
	end

	for (genvar k = 0; k < NQA_W; k++) begin : g_stage
		diva_t cur;
		if (k == 0) begin : g_first
			assign cur = in_d;
		end else begin : g_next
			assign cur = div_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= step_a(cur);
			end
		end
	end

	assign out_v = div_v_s[NQA_W-1];
	assign out_d = div_s[NQA_W-1];

endmodule

[src/cpl_div_b.sv]
`timescale 1ns / 1ps

module cpl_div_b
	import cpl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_v,
	input  diva_t in_d,
	output logic  out_v,
	output divb_t out_d
);

	localparam int SW = NQB_W + 1;

	logic                   v_s1, v_s2, v_s3;
	diva_t                  d_s1, d_s2;
	pp_t                    pp_s1;
	logic [NQA_W+MAG_W-1:0] prod_s2;
	divb_t                  head_s3;

	divb_t            div_s [NQB_W];
	logic [NQB_W-1:0] div_v_s;

	logic [DOT_W-1:0]     d4321_abs;
	logic [MP_W-1:0]      psum;
	logic                 prod_neg;
	logic signed [SW-1:0] ps, dsh, sum;
	logic [SW-1:0]        sum_abs;

	assign d4321_abs = in_d.d4321[DOT_W-1] ? -in_d.d4321 : in_d.d4321;
	assign psum      = pp_sum(pp_s1);
	assign prod_neg  = d_s2.neg ^ d_s2.d4321[DOT_W-1];
	assign ps        = prod_neg ? -$signed(SW'(prod_s2)) : $signed(SW'(prod_s2));
	assign dsh       = $signed(SW'($signed(d_s2.d1343))) <<< FRAC_BITS;
	assign sum       = ps + dsh;
	assign sum_abs   = sum[SW-1] ? -sum : sum;

	function automatic divb_t step_b(divb_t s);
		logic [MAG_W:0] t;
		logic           ge;
		divb_t          r;
		r     = s;
		t     = {s.rem, s.nq[NQB_W-1]};
		ge    = t >= {1'b0, s.den};
		r.rem = ge ? MAG_W'(t - {1'b0, s.den}) : t[MAG_W-1:0];
		r.nq  = {s.nq[NQB_W-2:0], ge};
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			div_v_s <= '0;
		end else if (en) begin
			v_s1    <= in_v;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			div_v_s <= {div_v_s[NQB_W-2:0], v_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= in_d;
			pp_s1   <= pp_mul(MA_W'(in_d.nq), MB_W'(d4321_abs));
			d_s2    <= d_s1;
			prod_s2 <= psum[NQA_W+MAG_W-1:0];
			// numerator of the second line parameter
			head_s3.g     <= d_s2.g;
			head_s3.found <= d_s2.found;
			head_s3.neg_a <= d_s2.neg;
			head_s3.mua   <= d_s2.nq;
			head_s3.den   <= d_s2.d4343;
			head_s3.rem   <= '0;
			head_s3.nq    <= sum_abs[NQB_W-1:0];
			head_s3.neg   <= sum[SW-1];
		end
	end

	for (genvar k = 0; k < NQB_W; k++) begin : g_stage
		divb_t cur;
		if (k == 0) begin : g_first
			assign cur = head_s3;
		end else begin : g_next
			assign cur = div_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= step_b(cur);
			end
		end
	end

	assign out_v = div_v_s[NQB_W-1];
	assign out_d = div_s[NQB_W-1];

endmodule

[src/cpl_back.sv]
`timescale 1ns / 1ps

module cpl_back
	import cpl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_v,
	input  divb_t in_d,
	output logic  out_v,
	output res_t  out_r
);

	logic               v_s1, v_s2;
	logic               found_s1, found_s2;
	logic [2:0][CW-1:0] oa_s1, ob_s1, oa_s2, ob_s2;
	pp_t                ppa_s1 [3];
	pp_t                ppb_s1 [3];
	logic [PA_W-1:0]    ma_s2 [3];
	logic [PB_W-1:0]    mb_s2 [3];
	logic [2:0]         sa_s1, sb_s1, sa_s2, sb_s2;
	logic [MP_W-1:0]    suma [3];
	logic [MP_W-1:0]    sumb [3];

	function automatic logic [CW-1:0] mag32(logic [CW-1:0] v);
		return v[CW-1] ? -v : v;
	endfunction

	function automatic logic [CW-1:0] sat32(logic signed [BW-1:0] x);
		logic [BW-CW:0] top;
		top = x[BW-1:CW-1];
		if ((&top) || !(|top)) begin
			return x[CW-1:0];
		end else if (x[BW-1]) begin
			return {1'b1, {(CW-1){1'b0}}};
		end else begin
			return {1'b0, {(CW-1){1'b1}}};
		end
	endfunction

	function automatic logic [CW-1:0] place(logic [BW-1:0] m, logic neg, logic [CW-1:0] o);
		logic signed [BW-1:0] sv;
		sv = neg ? -$signed(m) : $signed(m);
		return sat32(sv + $signed({{(BW-CW){o[CW-1]}}, o}));
	endfunction

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			suma[i] = pp_sum(ppa_s1[i]);
			sumb[i] = pp_sum(ppb_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1  <= in_v;
			v_s2  <= v_s1;
			out_v <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			found_s1 <= in_d.found;
			oa_s1    <= in_d.g.oa;
			ob_s1    <= in_d.g.ob;
			for (int i = 0; i < 3; i++) begin
				ppa_s1[i] <= pp_mul(MA_W'(in_d.mua), MB_W'(mag32(in_d.g.da[i])));
				ppb_s1[i] <= pp_mul(MA_W'(in_d.nq), MB_W'(mag32(in_d.g.db[i])));
				sa_s1[i]  <= in_d.neg_a ^ in_d.g.da[i][CW-1];
				sb_s1[i]  <= in_d.neg ^ in_d.g.db[i][CW-1];
			end
			found_s2 <= found_s1;
			oa_s2    <= oa_s1;
			ob_s2    <= ob_s1;
			sa_s2    <= sa_s1;
			sb_s2    <= sb_s1;
			for (int i = 0; i < 3; i++) begin
				ma_s2[i] <= suma[i][PA_W-1:0];
				mb_s2[i] <= sumb[i][PB_W-1:0];
			end
			out_r.found <= found_s2;
			for (int i = 0; i < 3; i++) begin
				if (found_s2) begin
					out_r.point_a[i] <= place(BW'(ma_s2[i] >> FRAC_BITS), sa_s2[i], oa_s2[i]);
					out_r.point_b[i] <= place(BW'(mb_s2[i] >> FRAC_BITS), sb_s2[i], ob_s2[i]);
				end else begin
					out_r.point_a[i] <= '0;
					out_r.point_b[i] <= '0;
				end
			end
		end
	end

endmodule

[src/closest_points_two_lines.sv]
`timescale 1ns / 1ps

// Closest points between two 3D lines in signed Q16.16. The block takes one query per
// clock while the pipeline advances and returns one result per query, in order: front
// stages form the dot products, their cross products and the denominator, the first
// line parameter is divided out one quotient bit per stage over 146 stages, three stages
// form the second numerator, its division takes 211 stages, and three stages scale the
// directions and saturate the points into the output register. The whole pipeline
// advances when the output register is empty or its result is taken, so a held result
// holds every stage. Lines whose denominator magnitude falls below parallel_threshold
// (units of 2^-32, reset 4) come out with found low and all points zero. Write
// parallel_threshold only while no query is in flight.
module closest_points_two_lines
	import cpl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [THR_W-1:0]    cfg_wdata,
	cpl_query_if.sink           query,
	cpl_result_if.source        result
);

	logic [THR_W-1:0] thr_q;
	logic             en;
	geom_t            qg;
	logic             fv, av, bv, ov;
	diva_t            fd, ad;
	divb_t            bd;
	res_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(4);
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign en          = !ov || result.ready;
	assign query.ready = en;

	assign qg.oa[0] = query.origin_a_x;
	assign qg.oa[1] = query.origin_a_y;
	assign qg.oa[2] = query.origin_a_z;
	assign qg.da[0] = query.dir_a_x;
	assign qg.da[1] = query.dir_a_y;
	assign qg.da[2] = query.dir_a_z;
	assign qg.ob[0] = query.origin_b_x;
	assign qg.ob[1] = query.origin_b_y;
	assign qg.ob[2] = query.origin_b_z;
	assign qg.db[0] = query.dir_b_x;
	assign qg.db[1] = query.dir_b_y;
	assign qg.db[2] = query.dir_b_z;

	cpl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (query.valid),
		.in_g   (qg),
		.thr    (thr_q),
		.out_v  (fv),
		.out_d  (fd)
	);

	cpl_div_a u_div_a (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (fv),
		.in_d   (fd),
		.out_v  (av),
		.out_d  (ad)
	);

	cpl_div_b u_div_b (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (av),
		.in_d   (ad),
		.out_v  (bv),
		.out_d  (bd)
	);

	cpl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (bv),
		.in_d   (bd),
		.out_v  (ov),
		.out_r  (res)
	);

	assign result.valid     = ov;
	assign result.point_a_x = res.point_a[0];
	assign result.point_a_y = res.point_a[1];
	assign result.point_a_z = res.point_a[2];
	assign result.point_b_x = res.point_b[0];
	assign result.point_b_y = res.point_b[1];
	assign result.point_b_z = res.point_b[2];
	assign result.found     = res.found;

endmodule
